// ===== sv/itoa_pkg.sv =====
// shared types, constants and helpers for the signed integer to ascii converter
`default_nettype none

package itoa_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned CHAR_W      = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DEC_DIGITS = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CH_A     = CHAR_W'(8'h61);
  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(8'h2d);
  localparam logic [CHAR_W-1:0] CH_NUL   = CHAR_W'(0);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]            radix;
  } itoa_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              bad_base;
  } itoa_out_t;

  // digit value to its ascii character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/itoa_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module itoa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/itoa_div.sv =====
// bit-serial restoring divider: one quotient bit per cycle
`default_nettype none

module itoa_div #(
  parameter int unsigned VALUE_W = itoa_pkg::VALUE_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [VALUE_W-1:0]                dividend_i,
  input  wire logic [itoa_pkg::RADIX_W-1:0]      divisor_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output logic      [VALUE_W-1:0]                quotient_o,
  output logic      [itoa_pkg::RADIX_W-1:0]      remainder_o
);
  import itoa_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [VALUE_W-1:0] quo_q, quo_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] div_q, div_d;

  logic [RADIX_W:0]   rem_sh;
  logic               ge;
  logic [RADIX_W:0]   rem_sub;

  assign rem_sh  = {rem_q, quo_q[VALUE_W-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(VALUE_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_W-2:0], ge};
      rem_d = ge ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== sv/signed_int_to_ascii_any_base.sv =====
// signed integer to ascii text in radix 2 to 36, one character per output beat
//
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | value, radix
//  out     | output    | out_valid_o / out_stall_i | character, last, bad_base
//
// each digit takes one pass of the shared bit-serial divider, and a negative
// value sends a leading '-' before its digits
// in_stall_o is high from accept until the last character is loaded into the
// output register, which then waits for the sink
// reset clears the sequencer and the output valid; digit ram needs no clearing
`default_nettype none

module signed_int_to_ascii_any_base (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire itoa_pkg::itoa_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output itoa_pkg::itoa_out_t      out_data_o
);
  import itoa_pkg::*;

  localparam int unsigned AW = $clog2(VALUE_WIDTH);
  localparam int unsigned NW = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_SIGN  = 6'b000100,
    S_FETCH = 6'b001000,
    S_SHOW  = 6'b010000,
    S_BAD   = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic               start_q, start_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               neg_q, neg_d;
  logic [NW-1:0]      ndig_q, ndig_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic               out_valid_q, out_valid_d;
  itoa_out_t          out_q, out_d;

  logic                   in_take;
  logic                   out_free;
  logic                   in_neg;
  logic                   in_bad;
  logic                   div_busy;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [RADIX_W-1:0]     div_rem;
  logic                   ram_we;
  logic                   ram_re;
  logic [CHAR_W-1:0]      ram_rdata;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_neg   = in_data_i.value[VALUE_WIDTH-1];
  assign in_bad   = (in_data_i.radix < RADIX_MIN) || (in_data_i.radix > RADIX_MAX);
  assign ram_we   = (state_q == S_DIV) && div_done;
  assign ram_re   = (state_q == S_FETCH);

  itoa_div #(
    .VALUE_W (VALUE_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .dividend_i  (mag_q),
    .divisor_i   (radix_q),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  itoa_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ndig_q[AW-1:0]),
    .wdata_i (digit_char(div_rem)),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    mag_d       = mag_q;
    radix_d     = radix_q;
    neg_d       = neg_q;
    ndig_d      = ndig_q;
    ptr_d       = ptr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          radix_d = in_data_i.radix;
          neg_d   = in_neg;
          mag_d   = in_neg ? (VALUE_WIDTH'(0) - VALUE_WIDTH'(in_data_i.value))
                           : VALUE_WIDTH'(in_data_i.value);
          ndig_d  = '0;
          if (in_bad) begin
            state_d = S_BAD;
          end else begin
            start_d = 1'b1;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          ndig_d = ndig_q + NW'(1);
          if (div_quo == '0) begin
            ptr_d   = ndig_q[AW-1:0];
            state_d = neg_q ? S_SIGN : S_FETCH;
          end else begin
            mag_d   = div_quo;
            start_d = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_d       = '{character: CH_MINUS, last: 1'b0, bad_base: 1'b0};
          out_valid_d = 1'b1;
          state_d     = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_SHOW;
      end
      S_SHOW: begin
        if (out_free) begin
          out_d       = '{character: ram_rdata, last: (ptr_q == '0), bad_base: 1'b0};
          out_valid_d = 1'b1;
          if (ptr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q - AW'(1);
            state_d = S_FETCH;
          end
        end
      end
      S_BAD: begin
        if (out_free) begin
          out_d       = '{character: CH_NUL, last: 1'b1, bad_base: 1'b1};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    radix_q <= radix_d;
    neg_q   <= neg_d;
    ndig_q  <= ndig_d;
    ptr_q   <= ptr_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the divider is only kicked when it is free
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> !div_busy)
    else $error("divider started while busy");

  // a bad radix beat is always a lone terminating nul
  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_base |-> out_data_o.last && (out_data_o.character == CH_NUL))
    else $error("bad radix beat malformed");

  // digit count never exceeds the ram depth
  a_ndig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (ndig_q < NW'(VALUE_WIDTH)))
    else $error("digit count overflow");

  // a new item is taken only once the previous text has been fully loaded
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !out_valid_q || $past(out_valid_q) || $past(state_q) == S_IDLE)
    else $error("item accepted mid-conversion");

endmodule

`default_nettype wire
